>>> design/ced_pkg.sv
package ced_pkg;

    localparam int unsigned CountWidth = 32;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned PtrWidth   = $clog2(QueueDepth);
    localparam int unsigned FillWidth  = $clog2(QueueDepth + 1);

    localparam logic [CountWidth-1:0] COUNT_MAX = '1;
    localparam logic [CountWidth-1:0] CAPACITY_RESET = '1;

    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X      = 8'h78;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef enum logic [2:0] {
        ST_PLAIN = 3'd0,
        ST_BACK  = 3'd1,
        ST_HEX   = 3'd2,
        ST_HEX1  = 3'd3,
        ST_OCT1  = 3'd4,
        ST_OCT2  = 3'd5
    } ced_state_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic                  dropped;
        logic [CountWidth-1:0] total_count;
        logic                  last;
    } ced_res_t;

    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                8'h61:   r = 8'h07;
                8'h62:   r = 8'h08;
                8'h66:   r = 8'h0C;
                8'h6E:   r = 8'h0A;
                8'h72:   r = 8'h0D;
                8'h74:   r = 8'h09;
                8'h76:   r = 8'h0B;
                default: r = c;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h37);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // letters carry their low nibble one to six, so add nine
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] r;
        begin
            if (c <= 8'h39)
                r = c[3:0];
            else
                r = c[3:0] + 4'd9;
            return r;
        end
    endfunction

    function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

>>> design/ced_in_if.sv
interface ced_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] char_in;

    modport source (output valid, output operation, output char_in, input ready);
    modport sink   (input valid, input operation, input char_in, output ready);
endinterface

>>> design/ced_out_if.sv
interface ced_out_if;
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic [7:0]                     data_byte;
    logic                           dropped;
    logic [ced_pkg::CountWidth-1:0] total_count;
    logic                           last;

    modport source (output valid, output kind, output data_byte, output dropped,
                    output total_count, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input dropped,
                    input total_count, input last, output ready);
endinterface

>>> design/c_escape_sequence_decoder_core.sv
// C string unescape engine. Each request carries one escaped text byte or an
// end-of-string marker; results are decoded bytes and, after an end marker, a
// saturating count of the bytes produced for that string. Bytes whose position
// reaches capacity_reg (set via cfg_wr_en/cfg_wr_data; the user must write it
// only while idle, which the block does not enforce) are still delivered and
// counted but flagged as dropped. A request is decoded in the cycle it is
// accepted and its zero, one or two results enter a four-entry result queue,
// so the first result is visible in the next cycle. A request is taken every
// cycle while at most two results are queued; as the output channel moves one
// result per cycle while the receiver is ready, two-result requests (an
// escape closed by a plain byte, or one flushed at the end) are throttled.
module c_escape_sequence_decoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    ced_in_if.sink                         in_ch,
    ced_out_if.source                      out_ch,
    input  logic                           cfg_wr_en,
    input  logic [ced_pkg::CountWidth-1:0] cfg_wr_data
);

    logic [ced_pkg::CountWidth-1:0] capacity_reg;
    ced_pkg::ced_state_t            state_reg, state_next;
    logic [3:0]                     first_digit_reg, first_digit_next;
    logic [2:0]                     second_digit_reg, second_digit_next;
    logic [ced_pkg::CountWidth-1:0] byte_count_reg, byte_count_next;

    ced_pkg::ced_res_t              queue_reg [ced_pkg::QueueDepth];
    logic [ced_pkg::PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ced_pkg::PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ced_pkg::FillWidth-1:0]  fill_reg, fill_next;

    logic                           in_fire, out_fire, is_end;
    logic [7:0]                     c;
    logic                           emit_a, emit_b, close_esc;
    logic [7:0]                     byte_a, byte_b, pending;
    logic [ced_pkg::CountWidth-1:0] cnt1, cnt2;
    ced_pkg::ced_res_t              res0, res1;
    logic [1:0]                     res_cnt;
    logic [ced_pkg::PtrWidth-1:0]   wr_ptr_inc;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign c        = in_ch.char_in;
    assign is_end   = (in_ch.operation == ced_pkg::OP_END);
    assign cnt1     = ced_pkg::sat_inc(byte_count_reg);
    assign cnt2     = ced_pkg::sat_inc(cnt1);

    // hold off while a two-result request could overflow the queue
    assign in_ch.ready = (fill_reg <= ced_pkg::FillWidth'(ced_pkg::QueueDepth - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= ced_pkg::CAPACITY_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ced_pkg::ST_PLAIN;
            first_digit_reg  <= '0;
            second_digit_reg <= '0;
            byte_count_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            first_digit_reg  <= first_digit_next;
            second_digit_reg <= second_digit_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        first_digit_next  = first_digit_reg;
        second_digit_next = second_digit_reg;
        emit_a            = 1'b0;
        emit_b            = 1'b0;
        byte_a            = '0;
        byte_b            = '0;
        close_esc         = 1'b0;
        pending           = '0;

        if (is_end)
        begin
            // flush whatever escape is still open
            unique case (state_reg)
                ced_pkg::ST_BACK:
                begin
                    emit_a = 1'b1;
                    byte_a = ced_pkg::CHAR_BSLASH;
                end
                ced_pkg::ST_HEX:
                begin
                    emit_a = 1'b1;
                    byte_a = ced_pkg::CHAR_X;
                end
                ced_pkg::ST_HEX1, ced_pkg::ST_OCT1:
                begin
                    emit_a = 1'b1;
                    byte_a = {4'd0, first_digit_reg};
                end
                ced_pkg::ST_OCT2:
                begin
                    emit_a = 1'b1;
                    byte_a = {1'b0, first_digit_reg, second_digit_reg};
                end
                default:
                begin
                    emit_a = 1'b0;
                end
            endcase
            state_next        = ced_pkg::ST_PLAIN;
            first_digit_next  = '0;
            second_digit_next = '0;
        end
        else
        begin
            unique case (state_reg)
                ced_pkg::ST_BACK:
                begin
                    if (ced_pkg::is_octal(c))
                    begin
                        first_digit_next = {1'b0, c[2:0]};
                        state_next       = ced_pkg::ST_OCT1;
                    end
                    else if (c == ced_pkg::CHAR_X)
                    begin
                        state_next = ced_pkg::ST_HEX;
                    end
                    else
                    begin
                        state_next = ced_pkg::ST_PLAIN;
                        emit_a     = 1'b1;
                        byte_a     = ced_pkg::simple_escape(c);
                    end
                end
                ced_pkg::ST_HEX:
                begin
                    if (ced_pkg::is_hex(c))
                    begin
                        first_digit_next = ced_pkg::hex_value(c);
                        state_next       = ced_pkg::ST_HEX1;
                    end
                    else
                    begin
                        close_esc = 1'b1;
                        pending   = ced_pkg::CHAR_X;
                    end
                end
                ced_pkg::ST_HEX1:
                begin
                    if (ced_pkg::is_hex(c))
                    begin
                        state_next = ced_pkg::ST_PLAIN;
                        emit_a     = 1'b1;
                        byte_a     = {first_digit_reg, ced_pkg::hex_value(c)};
                    end
                    else
                    begin
                        close_esc = 1'b1;
                        pending   = {4'd0, first_digit_reg};
                    end
                end
                ced_pkg::ST_OCT1:
                begin
                    if (ced_pkg::is_octal(c))
                    begin
                        second_digit_next = c[2:0];
                        state_next        = ced_pkg::ST_OCT2;
                    end
                    else
                    begin
                        close_esc = 1'b1;
                        pending   = {4'd0, first_digit_reg};
                    end
                end
                ced_pkg::ST_OCT2:
                begin
                    if (ced_pkg::is_octal(c))
                    begin
                        state_next = ced_pkg::ST_PLAIN;
                        emit_a     = 1'b1;
                        byte_a     = {first_digit_reg[1:0], second_digit_reg, c[2:0]};
                    end
                    else
                    begin
                        close_esc = 1'b1;
                        pending   = {1'b0, first_digit_reg, second_digit_reg};
                    end
                end
                default:
                begin
                    if (c == ced_pkg::CHAR_BSLASH)
                    begin
                        state_next = ced_pkg::ST_BACK;
                    end
                    else
                    begin
                        state_next = ced_pkg::ST_PLAIN;
                        emit_a     = 1'b1;
                        byte_a     = c;
                    end
                end
            endcase

            // escape closed by a non-digit: emit its value, then the character (a backslash opens a new escape)
            if (close_esc)
            begin
                emit_a = 1'b1;
                byte_a = pending;
                if (c == ced_pkg::CHAR_BSLASH)
                begin
                    state_next = ced_pkg::ST_BACK;
                end
                else
                begin
                    state_next = ced_pkg::ST_PLAIN;
                    emit_b     = 1'b1;
                    byte_b     = c;
                end
            end
        end

        if (!in_fire)
        begin
            state_next        = state_reg;
            first_digit_next  = first_digit_reg;
            second_digit_next = second_digit_reg;
        end
    end

    always_comb
    begin
        res0 = '0;
        res1 = '0;
        res_cnt = 2'd0;

        if (emit_a)
        begin
            res0.kind      = ced_pkg::KIND_DATA;
            res0.data_byte = byte_a;
            res0.dropped   = (byte_count_reg >= capacity_reg);
            res_cnt        = 2'd1;
            if (is_end)
            begin
                res1.kind        = ced_pkg::KIND_TOTAL;
                res1.total_count = cnt1;
                res1.last        = 1'b1;
                res_cnt          = 2'd2;
            end
            else if (emit_b)
            begin
                res1.kind      = ced_pkg::KIND_DATA;
                res1.data_byte = byte_b;
                res1.dropped   = (cnt1 >= capacity_reg);
                res1.last      = 1'b1;
                res_cnt        = 2'd2;
            end
            else
            begin
                res0.last = 1'b1;
            end
        end
        else if (is_end)
        begin
            res0.kind        = ced_pkg::KIND_TOTAL;
            res0.total_count = byte_count_reg;
            res0.last        = 1'b1;
            res_cnt          = 2'd1;
        end

        if (!in_fire)
        begin
            res_cnt = 2'd0;
        end

        if (!in_fire)
            byte_count_next = byte_count_reg;
        else if (is_end)
            byte_count_next = '0;
        else if (emit_b)
            byte_count_next = cnt2;
        else if (emit_a)
            byte_count_next = cnt1;
        else
            byte_count_next = byte_count_reg;
    end

    // result queue
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ced_pkg::PtrWidth'(res_cnt);
        rd_ptr_next = out_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + ced_pkg::FillWidth'(res_cnt)
                               - ced_pkg::FillWidth'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_cnt != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (res_cnt == 2'd2)
        begin
            queue_reg[wr_ptr_inc] <= res1;
        end
    end

    assign out_ch.valid       = (fill_reg != '0);
    assign out_ch.kind        = queue_reg[rd_ptr_reg].kind;
    assign out_ch.data_byte   = queue_reg[rd_ptr_reg].data_byte;
    assign out_ch.dropped     = queue_reg[rd_ptr_reg].dropped;
    assign out_ch.total_count = queue_reg[rd_ptr_reg].total_count;
    assign out_ch.last        = queue_reg[rd_ptr_reg].last;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ced_pkg::FillWidth'(ced_pkg::QueueDepth))
        else $error("result queue overfilled");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_end) |=> (byte_count_reg == '0) && (state_reg == ced_pkg::ST_PLAIN))
        else $error("end marker did not restart the string");

    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg == ced_pkg::COUNT_MAX && !(in_fire && is_end))
        |=> byte_count_reg == ced_pkg::COUNT_MAX)
        else $error("byte count left saturation");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_cnt != 2'd0) |=> out_ch.valid)
        else $error("produced result not presented");

endmodule

>>> test/tb_c_escape_sequence_decoder_core.sv
`timescale 1ns / 100ps

module tb_c_escape_sequence_decoder_core;

    localparam int WatchdogLimit = 3000;
    localparam int SettleCycles  = 4;
    localparam int HoldOffCycles = 200;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [ced_pkg::CountWidth-1:0] cfg_wr_data;

    ced_in_if  in_ch ();
    ced_out_if out_ch ();

    c_escape_sequence_decoder_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // decoder state as the block should hold it
    ced_pkg::ced_state_t            parse_st;
    logic [3:0]                     digit_hi;
    logic [2:0]                     digit_lo;
    logic [ced_pkg::CountWidth-1:0] bytes_made;
    logic [ced_pkg::CountWidth-1:0] capacity;
    int                             new_results;

    ced_pkg::ced_res_t expected_results[$];

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned requests_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_taken    = 0;
    int unsigned hold_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] unescape(input logic [7:0] c);
        case (c)
            "a":     return 8'h07;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "v":     return 8'h0B;
            default: return c;
        endcase
    endfunction

    function automatic bit octal_digit(input logic [7:0] c, output logic [2:0] v);
        v = c[2:0];
        return (c >= "0") && (c <= "7");
    endfunction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'h0;
        if ((c >= "0") && (c <= "9"))
        begin
            v = 4'(c - "0");
            return 1'b1;
        end
        if ((c >= "A") && (c <= "F"))
        begin
            v = 4'(c - "A" + 10);
            return 1'b1;
        end
        if ((c >= "a") && (c <= "f"))
        begin
            v = 4'(c - "a" + 10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        ced_pkg::ced_res_t r;
        r           = '0;
        r.kind      = ced_pkg::KIND_DATA;
        r.data_byte = b;
        r.dropped   = (bytes_made >= capacity);
        expected_results.push_back(r);
        new_results++;
        if (bytes_made != ced_pkg::COUNT_MAX)
            bytes_made++;
    endfunction

    function automatic void emit_total(input logic [ced_pkg::CountWidth-1:0] total);
        ced_pkg::ced_res_t r;
        r             = '0;
        r.kind        = ced_pkg::KIND_TOTAL;
        r.total_count = total;
        expected_results.push_back(r);
        new_results++;
    endfunction

    // a non-digit ends the pending escape; a backslash opens the next one
    function automatic void close_escape(input logic [7:0] pending, input logic [7:0] c);
        emit_byte(pending);
        if (c == ced_pkg::CHAR_BSLASH)
            parse_st = ced_pkg::ST_BACK;
        else
        begin
            parse_st = ced_pkg::ST_PLAIN;
            emit_byte(c);
        end
    endfunction

    function automatic void predict_request(input logic op, input logic [7:0] c);
        logic [3:0]        hv;
        logic [2:0]        ov;
        ced_pkg::ced_res_t tail;
        new_results = 0;
        if (op == ced_pkg::OP_END)
        begin
            case (parse_st)
                ced_pkg::ST_BACK:  emit_byte(ced_pkg::CHAR_BSLASH);
                ced_pkg::ST_HEX:   emit_byte(ced_pkg::CHAR_X);
                ced_pkg::ST_HEX1,
                ced_pkg::ST_OCT1:  emit_byte({4'h0, digit_hi});
                ced_pkg::ST_OCT2:  emit_byte({2'b00, digit_hi[2:0], digit_lo});
                default:           ;
            endcase
            emit_total(bytes_made);
            parse_st   = ced_pkg::ST_PLAIN;
            digit_hi   = '0;
            digit_lo   = '0;
            bytes_made = '0;
        end
        else
        begin
            case (parse_st)
                ced_pkg::ST_BACK:
                begin
                    if (octal_digit(c, ov))
                    begin
                        digit_hi = {1'b0, ov};
                        parse_st = ced_pkg::ST_OCT1;
                    end
                    else if (c == ced_pkg::CHAR_X)
                        parse_st = ced_pkg::ST_HEX;
                    else
                    begin
                        parse_st = ced_pkg::ST_PLAIN;
                        emit_byte(unescape(c));
                    end
                end
                ced_pkg::ST_HEX:
                begin
                    if (hex_digit(c, hv))
                    begin
                        digit_hi = hv;
                        parse_st = ced_pkg::ST_HEX1;
                    end
                    else
                        close_escape(ced_pkg::CHAR_X, c);
                end
                ced_pkg::ST_HEX1:
                begin
                    if (hex_digit(c, hv))
                    begin
                        parse_st = ced_pkg::ST_PLAIN;
                        emit_byte({digit_hi, hv});
                    end
                    else
                        close_escape({4'h0, digit_hi}, c);
                end
                ced_pkg::ST_OCT1:
                begin
                    if (octal_digit(c, ov))
                    begin
                        digit_lo = ov;
                        parse_st = ced_pkg::ST_OCT2;
                    end
                    else
                        close_escape({4'h0, digit_hi}, c);
                end
                ced_pkg::ST_OCT2:
                begin
                    // third digit: keep the low eight bits of the value
                    if (octal_digit(c, ov))
                    begin
                        parse_st = ced_pkg::ST_PLAIN;
                        emit_byte({digit_hi[1:0], digit_lo, ov});
                    end
                    else
                        close_escape({2'b00, digit_hi[2:0], digit_lo}, c);
                end
                default:
                begin
                    if (c == ced_pkg::CHAR_BSLASH)
                        parse_st = ced_pkg::ST_BACK;
                    else
                    begin
                        parse_st = ced_pkg::ST_PLAIN;
                        emit_byte(c);
                    end
                end
            endcase
        end
        if (new_results > 0)
        begin
            tail      = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        $display("%0t: result %0d, %s: expected 0x%0h, got 0x%0h",
                 $time, results_seen, what, want, seen);
        mismatches++;
    endtask

    // entered and left at a falling edge
    task automatic send_request(input logic op, input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.operation = op;
        in_ch.char_in   = c;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_request(op, c);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_request(ced_pkg::OP_CHAR, s[i]);
    endtask

    task automatic send_end();
        send_request(ced_pkg::OP_END, 8'($urandom));
    endtask

    // one token of escaped text or an end marker: mostly well-formed escapes, some raw noise
    task automatic send_token();
        string esc_letters;
        string hex_letters;
        int    pick;
        logic [7:0] c;
        esc_letters = "'\"?\\abfnrtvqzE8";
        hex_letters = "0123456789abcdefABCDEF";
        pick        = $urandom_range(99);
        if (pick < 7)
            send_end();
        else if (pick < 20)
            send_request(ced_pkg::OP_CHAR, 8'($urandom));
        else if (pick < 40)
        begin
            c = 8'($urandom_range(32, 126));
            if (c == ced_pkg::CHAR_BSLASH)
                c = "9";
            send_request(ced_pkg::OP_CHAR, c);
        end
        else if (pick < 60)
        begin
            send_request(ced_pkg::OP_CHAR, ced_pkg::CHAR_BSLASH);
            send_request(ced_pkg::OP_CHAR,
                         esc_letters[$urandom_range(esc_letters.len() - 1)]);
        end
        else if (pick < 80)
        begin
            send_request(ced_pkg::OP_CHAR, ced_pkg::CHAR_BSLASH);
            repeat ($urandom_range(1, 3))
                send_request(ced_pkg::OP_CHAR, 8'(8'h30 + $urandom_range(7)));
        end
        else
        begin
            send_request(ced_pkg::OP_CHAR, ced_pkg::CHAR_BSLASH);
            send_request(ced_pkg::OP_CHAR, ced_pkg::CHAR_X);
            repeat ($urandom_range(0, 2))
                send_request(ced_pkg::OP_CHAR,
                             hex_letters[$urandom_range(hex_letters.len() - 1)]);
        end
    endtask

    // hold the sender until every expected result is in, then let the block settle
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_capacity(input logic [ced_pkg::CountWidth-1:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        capacity    = value;
    endtask

    task automatic test_directed_escapes();
        send_request(ced_pkg::OP_CHAR, 8'h00);
        send_request(ced_pkg::OP_CHAR, 8'hFF);
        send_text("\\777");     // three octal digits, truncated to a byte
        send_text("\\12\\q");   // two-digit octal closed by a new escape, then unknown escape
        send_text("\\xG");      // \x with no hex digit
        send_text("\\xfA");
        send_text("\\x4");
        send_end();             // flush a single hex digit
        send_text("\\");
        send_end();             // flush a lone backslash
        send_end();             // empty string
    endtask

    task automatic test_capacity_limits();
        set_capacity('0);
        send_text("a\\n\\x");
        send_end();
        set_capacity(32'd1);
        send_text("\\5z\\61");
        send_end();
        send_text("\\5");
        send_end();
    endtask

    task automatic test_full_queue_stall();
        set_capacity(32'd6);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // receiver holds off for a long stretch while requests keep coming
        hold_requests <= hold_requests + 1;
        repeat (30) send_token();
        wait_drained();
        repeat (20) send_token();
        wait_drained();
    endtask

    task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct,
                             input logic [ced_pkg::CountWidth-1:0] cap,
                             input int unsigned count);
        int unsigned stop_at;
        set_capacity(cap);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        stop_at        = requests_sent + count;
        while (requests_sent < stop_at)
            send_token();
    endtask

    task automatic test_random_traffic();
        run_phase(0, 0, ced_pkg::CAPACITY_RESET, 120);
        run_phase(52, 0, 32'd2, 120);
        run_phase(0, 52, 32'($urandom_range(0, 12)), 120);
        run_phase(21, 21, 32'hFFFF_FFFE, 120);
        run_phase(0, 0, 32'($urandom), 80);
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != holds_taken)
        begin
            holds_taken = hold_requests;
            hold_left   = HoldOffCycles;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", '0,
                                {24'h0, out_ch.data_byte});
            else
            begin
                if (out_ch.kind !== expected_results[0].kind)
                    report_mismatch("kind", 32'(expected_results[0].kind),
                                    32'(out_ch.kind));
                if (out_ch.data_byte !== expected_results[0].data_byte)
                    report_mismatch("data_byte", 32'(expected_results[0].data_byte),
                                    32'(out_ch.data_byte));
                if (out_ch.dropped !== expected_results[0].dropped)
                    report_mismatch("dropped", 32'(expected_results[0].dropped),
                                    32'(out_ch.dropped));
                if (out_ch.total_count !== expected_results[0].total_count)
                    report_mismatch("total_count", expected_results[0].total_count,
                                    out_ch.total_count);
                if (out_ch.last !== expected_results[0].last)
                    report_mismatch("last", 32'(expected_results[0].last),
                                    32'(out_ch.last));
                void'(expected_results.pop_front());
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = ced_pkg::OP_CHAR;
        in_ch.char_in   = '0;
        out_ch.ready    = 1'b0;
        parse_st        = ced_pkg::ST_PLAIN;
        digit_hi        = '0;
        digit_lo        = '0;
        bytes_made      = '0;
        capacity        = ced_pkg::CAPACITY_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_escapes();
        test_capacity_limits();
        test_full_queue_stall();
        test_random_traffic();

        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), '0);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
design/ced_pkg.sv
design/ced_in_if.sv
design/ced_out_if.sv
design/c_escape_sequence_decoder_core.sv
test/tb_c_escape_sequence_decoder_core.sv
